### hdl/scc_pkg.sv
package scc_pkg;

  // Item kinds carried on s_tuser.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_SCAN  = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_VIEW_WIDTH  = 1'b0;
  localparam logic CFG_VIEW_HEIGHT = 1'b1;

  localparam logic [8:0] VIEW_WIDTH_RESET  = 9'd240;
  localparam logic [7:0] VIEW_HEIGHT_RESET = 8'd160;

  localparam int unsigned HALF_BITS = 64;
  localparam int unsigned COUNT_W   = 8;

  localparam logic [7:0] Y_WRAP_AT = 8'd160;
  localparam logic [2:0] SHAPE_BAD = 3'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_RUN,
    ST_LAST
  } scan_state_t;

  // Box width indexed by shape*4+size.
  function automatic logic [6:0] box_width(input logic [3:0] idx);
    logic [6:0] w;
    case (idx)
      4'd0:    w = 7'd8;
      4'd1:    w = 7'd16;
      4'd2:    w = 7'd32;
      4'd3:    w = 7'd64;
      4'd4:    w = 7'd16;
      4'd5:    w = 7'd32;
      4'd6:    w = 7'd32;
      4'd7:    w = 7'd64;
      4'd8:    w = 7'd8;
      4'd9:    w = 7'd8;
      4'd10:   w = 7'd16;
      4'd11:   w = 7'd32;
      default: w = 7'd0;
    endcase
    return w;
  endfunction

  // Box height indexed by shape*4+size.
  function automatic logic [6:0] box_height(input logic [3:0] idx);
    logic [6:0] h;
    case (idx)
      4'd0:    h = 7'd8;
      4'd1:    h = 7'd16;
      4'd2:    h = 7'd32;
      4'd3:    h = 7'd64;
      4'd4:    h = 7'd8;
      4'd5:    h = 7'd8;
      4'd6:    h = 7'd16;
      4'd7:    h = 7'd32;
      4'd8:    h = 7'd16;
      4'd9:    h = 7'd32;
      4'd10:   h = 7'd32;
      4'd11:   h = 7'd64;
      default: h = 7'd0;
    endcase
    return h;
  endfunction

endpackage

### hdl/scc_store.sv
module scc_store #(
  parameter int DEPTH = 128,
  parameter int IDX_W = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [31:0]      wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [31:0]      rd_data
);

  logic [31:0]      mem [DEPTH];
  logic [DEPTH-1:0] written;
  logic [31:0]      rd_word;
  logic             rd_written;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  // An entry that was never written since reset reads as all zeros.
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_written <= written[rd_addr];
      end
    end
  end

  assign rd_data = rd_written ? rd_word : 32'd0;

endmodule

### hdl/scc_eval.sv
module scc_eval (
  input  logic [31:0] word,
  input  logic [7:0]  line,
  input  logic [8:0]  view_width,
  output logic        visible
);

  logic [15:0]        a0;
  logic [15:0]        a1;
  logic               affine;
  logic               bit9;
  logic [1:0]         shape;
  logic [3:0]         tidx;
  logic [7:0]         w;
  logic [7:0]         h;
  logic signed [10:0] y_s;
  logic signed [10:0] y_end;
  logic signed [10:0] ln_s;
  logic [8:0]         x;
  logic [9:0]         x_end;
  logic               hidden;
  logic               vis_v;
  logic               vis_h;

  always_comb begin
    a0     = word[15:0];
    a1     = word[31:16];
    affine = a0[8];
    bit9   = a0[9];
    shape  = a0[15:14];
    tidx   = {shape, a1[15:14]};
    hidden = (!affine && bit9) || ({1'b0, shape} == scc_pkg::SHAPE_BAD);

    w = {1'b0, scc_pkg::box_width(tidx)};
    h = {1'b0, scc_pkg::box_height(tidx)};
    if (affine && bit9) begin
      w = {w[6:0], 1'b0};
      h = {h[6:0], 1'b0};
    end

    // Y at the wrap point or above stands for Y-256.
    if (a0[7:0] >= scc_pkg::Y_WRAP_AT) begin
      y_s = {3'b111, a0[7:0]};
    end else begin
      y_s = {3'b000, a0[7:0]};
    end
    y_end = y_s + $signed({3'b000, h});
    ln_s  = $signed({3'b000, line});
    vis_v = (ln_s >= y_s) && (ln_s < y_end);

    // An X below the frame width is on screen at once. One at or past it
    // stands for X-512 and shows only if its right edge reaches past zero.
    x     = a1[8:0];
    x_end = {1'b0, x} + {2'b00, w};
    vis_h = (x < view_width) || (x_end > 10'd512);

    visible = !hidden && vis_v && vis_h;
  end

endmodule

### hdl/sprite_scanline_cull.sv
// Channel  Dir  Fields (tdata from bit 0 up)                              Side
// s_       in   tdata: entry_index, attr_word0, attr_word1, line, 1 pad   tuser: action
// m_       out  tdata: visible_mask, visible_count                        tuser: half_select
//                                                                          tlast: last
// cfg_     in   cfg_index: register, cfg_data: value (9 bits)
//
// Writes are accepted while the engine is idle, where s_tready stays high, so they can follow
// back to back. A scan holds s_tready low through, per half, a wait state, 64 reads from the
// table memory and a closing state; the upper half's wait state also lasts until the lower
// result drains. Each half waits for an empty output register, so a stalled receiver stretches
// the scan. Reset gives view_width 240, view_height 160, and unwritten entries read as zero
// through per-entry written bits with no clearing pass.
module sprite_scanline_cull #(
  parameter int ENTRY_COUNT = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // entry_index, attr_word0, attr_word1, line
  input  logic        s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // visible_mask, visible_count
  output logic        m_tuser,   // half_select
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam logic [7:0] ENTRY_LIMIT = 8'(ENTRY_COUNT);

  scc_pkg::scan_state_t state;
  scc_pkg::scan_state_t state_next;

  logic [8:0]  view_width;
  logic [7:0]  view_height;
  logic [6:0]  in_index;
  logic [31:0] in_word;
  logic [7:0]  in_line;
  logic        in_accept;

  logic [7:0]  scan_line;
  logic        line_ok;
  logic [6:0]  cnt;
  logic        in_range;
  logic        rd_en;
  logic        wr_en;
  logic [31:0] rd_data;

  logic        ev_active;
  logic        ev_in_range;
  logic        ev_half;
  logic        eval_hit;
  logic        vis;
  logic [63:0] mask;
  logic [63:0] mask_next;
  logic [7:0]  running;
  logic [7:0]  running_next;

  logic [63:0] out_mask;
  logic [7:0]  out_count;
  logic        out_half;

  assign in_index  = s_tdata[6:0];
  assign in_word   = {s_tdata[38:23], s_tdata[22:7]};
  assign in_line   = s_tdata[46:39];
  assign in_accept = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_width  <= scc_pkg::VIEW_WIDTH_RESET;
      view_height <= scc_pkg::VIEW_HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        scc_pkg::CFG_VIEW_WIDTH:  view_width  <= cfg_data;
        scc_pkg::CFG_VIEW_HEIGHT: view_height <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      scc_pkg::ST_IDLE: begin
        if (in_accept && (s_tuser == scc_pkg::ACT_SCAN)) begin
          state_next = scc_pkg::ST_WAIT;
        end
      end
      scc_pkg::ST_WAIT: begin
        if (!m_tvalid) begin
          state_next = scc_pkg::ST_RUN;
        end
      end
      scc_pkg::ST_RUN: begin
        if (cnt[5:0] == 6'h3F) begin
          state_next = scc_pkg::ST_LAST;
        end
      end
      scc_pkg::ST_LAST: begin
        state_next = ev_half ? scc_pkg::ST_IDLE : scc_pkg::ST_WAIT;
      end
      default: state_next = scc_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    s_tready = 1'b0;
    rd_en    = 1'b0;
    case (state)
      scc_pkg::ST_IDLE: s_tready = 1'b1;
      scc_pkg::ST_WAIT: ;
      scc_pkg::ST_RUN:  rd_en    = 1'b1;
      scc_pkg::ST_LAST: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign wr_en    = in_accept && (s_tuser == scc_pkg::ACT_WRITE) &&
                    ({1'b0, in_index} < ENTRY_LIMIT);
  assign in_range = {1'b0, cnt} < ENTRY_LIMIT;

  scc_store #(
    .DEPTH (ENTRY_COUNT),
    .IDX_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (in_index[IDX_W-1:0]),
    .wr_data (in_word),
    .rd_en   (rd_en && in_range),
    .rd_addr (cnt[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  scc_eval u_eval (
    .word       (rd_data),
    .line       (scan_line),
    .view_width (view_width),
    .visible    (eval_hit)
  );

  // Entries past the store and lines past the frame never count.
  assign vis          = ev_in_range && line_ok && eval_hit;
  assign mask_next    = {vis, mask[63:1]};
  assign running_next = running + {7'd0, vis};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      ev_active <= 1'b0;
      running   <= '0;
    end else begin
      ev_active <= rd_en;
      if (in_accept && (s_tuser == scc_pkg::ACT_SCAN)) begin
        cnt     <= '0;
        running <= '0;
      end else begin
        if (rd_en) begin
          cnt <= cnt + 7'd1;
        end
        if (ev_active) begin
          running <= running_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && (s_tuser == scc_pkg::ACT_SCAN)) begin
      scan_line <= in_line;
      line_ok   <= in_line < view_height;
    end
    if (rd_en) begin
      ev_in_range <= in_range;
      ev_half     <= cnt[6];
    end
    if (ev_active) begin
      mask <= mask_next;
    end
  end

  // Output register; the engine loads it only after it has drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == scc_pkg::ST_LAST) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == scc_pkg::ST_LAST) begin
      out_mask  <= mask_next;
      out_count <= running_next;
      out_half  <= ev_half;
    end
  end

  assign m_tdata = {out_count, out_mask};
  assign m_tuser = out_half;
  assign m_tlast = out_half;

  a_push_into_empty: assert property (@(posedge clk) disable iff (rst)
    (state == scc_pkg::ST_LAST) |-> !m_tvalid)
    else $error("result pushed while output register still full");

  a_scan_starts_wait: assert property (@(posedge clk) disable iff (rst)
    (in_accept && (s_tuser == scc_pkg::ACT_SCAN)) |=> (state == scc_pkg::ST_WAIT))
    else $error("scan item did not start the engine");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_count <= ENTRY_LIMIT))
    else $error("visible count exceeds the entry count");

  a_last_eval_live: assert property (@(posedge clk) disable iff (rst)
    (state == scc_pkg::ST_LAST) |-> ev_active)
    else $error("half closed without a pending evaluation");

  a_no_read_when_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !rd_en)
    else $error("memory read while accepting items");

endmodule

### bench/sprite_scanline_cull_test.sv
`timescale 1ns / 100ps

module sprite_scanline_cull_test;

  typedef struct packed {
    logic        action;
    logic [6:0]  entry;
    logic [15:0] word0;
    logic [15:0] word1;
    logic [7:0]  line;
  } sprite_item_t;

  typedef struct {
    logic [63:0] mask;
    logic        half;
    logic [7:0]  count;
    logic        last;
  } cull_half_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [8:0]  cfg_data = '0;

  sprite_scanline_cull dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the sprite table and the frame registers.
  logic [31:0] attr_shadow [128];
  logic [8:0]  width_shadow = 9'd240;
  logic [7:0]  height_shadow = 8'd160;

  int box_w_tab [12] = '{8, 16, 32, 64, 16, 32, 32, 64, 8, 8, 16, 32};
  int box_h_tab [12] = '{8, 16, 32, 64, 8, 8, 16, 32, 16, 32, 32, 64};

  sprite_item_t pending_items[$];
  cull_half_t   expected_halves[$];
  sprite_item_t offered_item;

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int mismatches = 0;
  bit hold_go = 1'b0;
  logic long_hold = 1'b0;

  function automatic bit sprite_on_line(logic [31:0] word, int ln);
    logic [15:0] a0;
    logic [15:0] a1;
    int w;
    int h;
    int y;
    int x;
    int fw;
    a0 = word[15:0];
    a1 = word[31:16];
    // Bit 9 without the affine bit hides the sprite; shape 3 is not a valid shape.
    if (!a0[8] && a0[9]) return 1'b0;
    if (a0[15:14] == 2'd3) return 1'b0;
    w = box_w_tab[a0[15:14] * 4 + a1[15:14]];
    h = box_h_tab[a0[15:14] * 4 + a1[15:14]];
    if (a0[8] && a0[9]) begin
      w = w * 2;
      h = h * 2;
    end
    y = a0[7:0];
    if (y >= 160) y = y - 256;
    if (ln < y || ln >= y + h) return 1'b0;
    fw = width_shadow;
    x = a1[8:0];
    if (x >= fw) x = x - 512;
    if (x + w <= 0 || x >= fw) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void predict_scan(logic [7:0] ln);
    cull_half_t res [2];
    int running;
    running = 0;
    for (int hf = 0; hf < 2; hf++) begin
      res[hf].mask = '0;
      res[hf].half = hf[0];
      res[hf].last = hf[0];
      if (ln < height_shadow) begin
        for (int b = 0; b < 64; b++) begin
          if (sprite_on_line(attr_shadow[hf * 64 + b], ln)) begin
            res[hf].mask[b] = 1'b1;
            running++;
          end
        end
      end
      res[hf].count = running[7:0];
      expected_halves.push_back(res[hf]);
    end
  endfunction

  function automatic void apply_item(sprite_item_t it);
    if (it.action == scc_pkg::ACT_WRITE) attr_shadow[it.entry] = {it.word1, it.word0};
    else predict_scan(it.line);
  endfunction

  // Input side: one transfer per handshake, next item chosen when the bus is free.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) apply_item(offered_item);
      if (!s_tvalid || s_tready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          offered_item = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {1'b0, offered_item.line, offered_item.word1, offered_item.word0,
                       offered_item.entry};
          s_tuser  <= offered_item.action;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_half();
    cull_half_t want;
    if (expected_halves.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: mask=%h count=%0d half=%b last=%b",
                 m_tdata[63:0], m_tdata[71:64], m_tuser, m_tlast);
    end else begin
      want = expected_halves.pop_front();
      if (m_tdata[63:0] !== want.mask || m_tdata[71:64] !== want.count ||
          m_tuser !== want.half || m_tlast !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch exp/got: mask %h/%h count %0d/%0d half %b/%b last %b/%b",
                   want.mask, m_tdata[63:0], want.count, m_tdata[71:64],
                   want.half, m_tuser, want.last, m_tlast);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_half();
      m_tready <= !long_hold && ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Long receiver hold-off while the sender keeps offering items.
  initial begin
    wait (hold_go);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (600) @(posedge clk);
    long_hold <= 1'b0;
  end

  task automatic queue_write(logic [6:0] idx, logic [15:0] w0, logic [15:0] w1);
    pending_items.push_back('{action: scc_pkg::ACT_WRITE, entry: idx, word0: w0, word1: w1,
                              line: 8'd0});
  endtask

  task automatic queue_scan(logic [7:0] ln);
    pending_items.push_back('{action: scc_pkg::ACT_SCAN, entry: 7'd0, word0: 16'd0,
                              word1: 16'd0, line: ln});
  endtask

  function automatic sprite_item_t random_item();
    sprite_item_t it;
    int r;
    it = sprite_item_t'(48'({$urandom, $urandom}));
    if ($urandom_range(99) < 35) begin
      it.action = scc_pkg::ACT_SCAN;
      it.line = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                         : 8'($urandom_range(height_shadow));
    end else begin
      it.action = scc_pkg::ACT_WRITE;
      // Most writes are sane sprites placed near the frame; the rest are raw noise.
      if ($urandom_range(3) != 0) begin
        it.word0[15:14] = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
        r = $urandom_range(9);
        if (r == 0) it.word0[9:8] = 2'b10;
        else if (r <= 3) it.word0[9:8] = 2'b11;
        else if (r <= 5) it.word0[9:8] = 2'b01;
        else it.word0[9:8] = 2'b00;
        if ($urandom_range(3) != 0) it.word1[8:0] = 9'($urandom_range(width_shadow));
      end
    end
    return it;
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || s_tvalid || expected_halves.size() != 0);
    // Let a trailing write settle in the table memory.
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [8:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == scc_pkg::CFG_VIEW_WIDTH) width_shadow = val;
    else height_shadow = val[7:0];
  endtask

  initial begin
    int widths [6];
    int heights [6];
    for (int i = 0; i < 128; i++) attr_shadow[i] = '0;
    widths  = '{511, 1, 256, 0, 240, 0};
    heights = '{255, 1, 200, 0, 160, 0};
    widths[3]  = $urandom_range(1, 511);
    heights[3] = $urandom_range(1, 255);
    widths[5]  = $urandom_range(1, 511);
    heights[5] = $urandom_range(1, 255);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed sprites against the reset frame of 240 x 160.
    @(negedge clk);
    queue_write(7'd0,   16'h000A, 16'h0014);   // plain 8x8 at line 10
    queue_write(7'd1,   16'h020A, 16'h0014);   // hidden
    queue_write(7'd2,   16'hC00A, 16'h0014);   // invalid shape
    queue_write(7'd3,   16'h43C8, 16'hC1F4);   // double-size affine, Y and X both wrap
    queue_write(7'd4,   16'h010C, 16'h0064);   // plain affine
    queue_write(7'd63,  16'h8000, 16'hC0EF);   // tall sprite on the last visible column
    queue_write(7'd64,  16'h000A, 16'h00F0);   // X equal to frame width wraps far left
    queue_write(7'd65,  16'h000A, 16'h01F8);   // right edge lands exactly on column 0
    queue_write(7'd66,  16'h000A, 16'h01F9);   // one pixel pokes into the frame
    queue_write(7'd100, 16'h009F, 16'hC000);   // Y just below the wrap point
    queue_write(7'd101, 16'h00A0, 16'hC000);   // Y at the wrap point, entirely above
    queue_write(7'd127, 16'hFFFF, 16'hFFFF);
    queue_scan(8'd0);
    queue_scan(8'd10);
    queue_scan(8'd12);
    queue_scan(8'd159);
    queue_scan(8'd160);
    queue_scan(8'd255);
    queue_scan(8'd5);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(scc_pkg::CFG_VIEW_WIDTH, 9'(widths[ph]));
      write_reg(scc_pkg::CFG_VIEW_HEIGHT, 9'(heights[ph]));
      case (ph % 4)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 52;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 52;
        end
        default: begin
          sender_idle_pct = 14;
          receiver_stall_pct = 14;
        end
      endcase
      @(negedge clk);
      for (int n = 0; n < 205; n++) pending_items.push_back(random_item());
      if (ph == 2) hold_go = 1'b1;
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
